@@ sv/lbra_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, word types and the Pascal-triangle table for the row accumulator.
package lbra_pkg;

	localparam int COEFF_DEPTH = 128;
	localparam int MAX_CYCLES  = 33;

	localparam int COEF_W  = 32;
	localparam int ADDR_W  = $clog2(COEFF_DEPTH);
	localparam int CYC_W   = 6;
	localparam int WGT_W   = 6;
	localparam int SHIFT_W = 7;
	localparam int RIDX_W  = 7;
	localparam int BASE_W  = 11;

	localparam int ROW       = MAX_CYCLES + 1;
	localparam int ROM_DEPTH = ROW * ROW;
	localparam int ROM_AW    = $clog2(ROM_DEPTH);

	typedef enum logic [1:0] {
		OP_ACCUMULATE,
		OP_READ,
		OP_CLEAR,
		OP_NOP
	} lbra_op_t;

	typedef struct packed {
		lbra_op_t             operation;
		logic [CYC_W-1:0]     cycles;
		logic [WGT_W-1:0]     weight;
		logic [SHIFT_W-1:0]   deg_offset;
		logic [RIDX_W-1:0]    read_index;
	} lbra_cmd_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] coefficient;
		logic                     wrapped;
		logic                     out_of_range;
	} lbra_result_t;

	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [COEF_W-1:0] wr_data;
		logic              clr;
	} lbra_store_req_t;

	typedef logic [COEF_W-1:0] pascal_t [ROM_DEPTH];

	// row n of the triangle sits at n*ROW .. n*ROW+n
	function automatic pascal_t pascal_table();
		pascal_t t;
		for (int i = 0; i < ROM_DEPTH; i++) begin
			t[i] = '0;
		end
		for (int n = 0; n < ROW; n++) begin
			t[n*ROW] = COEF_W'(1);
			for (int k = 1; k <= n; k++) begin
				t[n*ROW+k] = t[(n-1)*ROW+k-1] + ((k < n) ? t[(n-1)*ROW+k] : '0);
			end
		end
		return t;
	endfunction

endpackage

@@ sv/lbra_rom.sv @@
`timescale 1ns / 1ps
// Pascal-triangle coefficient ROM with registered read.
module lbra_rom (
	input  logic                       clk,
	input  logic [lbra_pkg::ROM_AW-1:0] addr,
	output logic [lbra_pkg::COEF_W-1:0] data
);
	import lbra_pkg::*;

	localparam pascal_t PASCAL = pascal_table();

	logic [COEF_W-1:0] data_q;

	always_ff @(posedge clk) begin
		data_q <= PASCAL[addr];
	end

	assign data = data_q;

endmodule

@@ sv/lbra_store.sv @@
`timescale 1ns / 1ps
// Coefficient store: memory with per-entry valid bits, one read and one write port.
module lbra_store (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lbra_pkg::lbra_store_req_t    req,
	output logic [lbra_pkg::COEF_W-1:0]  rdata
);
	import lbra_pkg::*;

	logic [COEF_W-1:0]      mem_q [COEFF_DEPTH];
	logic [COEFF_DEPTH-1:0] valid_q;
	logic [COEF_W-1:0]      rd_data_q;
	logic                   rd_valid_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem_q[req.rd_addr];
		end
	end

	// invalid entries read as zero; clear drops all valid bits at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.clr) begin
				valid_q <= '0;
			end else if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_valid_q <= valid_q[req.rd_addr];
			end
		end
	end

	assign rdata = rd_valid_q ? rd_data_q : '0;

endmodule

@@ sv/lbra_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer and shared add/subtract unit for the read-modify-write walk.
module lbra_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  lbra_pkg::lbra_cmd_t           cmd,
	output logic                          busy,
	output logic                          done,
	output lbra_pkg::lbra_result_t        result,
	output lbra_pkg::lbra_store_req_t     store_req,
	input  logic [lbra_pkg::COEF_W-1:0]   store_rdata,
	output logic [lbra_pkg::ROM_AW-1:0]   rom_addr,
	input  logic [lbra_pkg::COEF_W-1:0]   rom_data
);
	import lbra_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_WALK,
		ST_DRAIN,
		ST_RDWAIT
	} state_t;

	state_t             state_q;
	lbra_cmd_t          cmd_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [CYC_W-1:0]   k_q;
	logic               wrap_q;
	logic               issue_s1;
	logic [ADDR_W-1:0]  wr_addr_s1;
	logic               done_q;
	lbra_result_t       result_q;

	logic signed [BASE_W-1:0] base;
	logic signed [BASE_W-1:0] top_idx;
	logic                     acc_oor;
	logic                     rd_oor;
	logic                     sub;
	logic [COEF_W-1:0]        sum;
	logic                     cur_wrap;

	always_comb begin
		base    = BASE_W'(cmd_q.deg_offset) + BASE_W'(cmd_q.weight)
			- BASE_W'(cmd_q.cycles);
		top_idx = base + BASE_W'({cmd_q.cycles, 1'b0});
		acc_oor = (cmd_q.cycles > CYC_W'(MAX_CYCLES)) || (base < 0)
			|| (top_idx >= $signed(BASE_W'(COEFF_DEPTH)));
		rd_oor  = int'(cmd_q.read_index) >= COEFF_DEPTH;
		sub     = cmd_q.weight[0];
		sum     = sub ? (store_rdata - rom_data) : (store_rdata + rom_data);
		if (sub) begin
			cur_wrap = (store_rdata[COEF_W-1] != rom_data[COEF_W-1])
				&& (sum[COEF_W-1] != store_rdata[COEF_W-1]);
		end else begin
			cur_wrap = (store_rdata[COEF_W-1] == rom_data[COEF_W-1])
				&& (sum[COEF_W-1] != store_rdata[COEF_W-1]);
		end
	end

	always_comb begin
		store_req.rd_en   = (state_q == ST_WALK)
			|| ((state_q == ST_SETUP) && (cmd_q.operation == OP_READ) && !rd_oor);
		store_req.rd_addr = (state_q == ST_WALK) ? addr_q : ADDR_W'(cmd_q.read_index);
		store_req.wr_en   = issue_s1;
		store_req.wr_addr = wr_addr_s1;
		store_req.wr_data = sum;
		store_req.clr     = (state_q == ST_SETUP) && (cmd_q.operation == OP_CLEAR);
		rom_addr          = ROM_AW'(int'(cmd_q.cycles) * ROW + int'(k_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cmd_q      <= '0;
			addr_q     <= '0;
			k_q        <= '0;
			wrap_q     <= 1'b0;
			issue_s1   <= 1'b0;
			wr_addr_s1 <= '0;
			done_q     <= 1'b0;
			result_q   <= '0;
		end else begin
			done_q     <= 1'b0;
			issue_s1   <= 1'b0;
			wr_addr_s1 <= addr_q;
			if (issue_s1 && cur_wrap) begin
				wrap_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						cmd_q   <= cmd;
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					result_q <= '0;
					case (cmd_q.operation)
						OP_ACCUMULATE: begin
							if (acc_oor) begin
								result_q.out_of_range <= 1'b1;
								done_q                <= 1'b1;
								state_q               <= ST_IDLE;
							end else begin
								addr_q  <= ADDR_W'(base);
								k_q     <= '0;
								wrap_q  <= 1'b0;
								state_q <= ST_WALK;
							end
						end
						OP_READ: begin
							if (rd_oor) begin
								result_q.out_of_range <= 1'b1;
								done_q                <= 1'b1;
								state_q               <= ST_IDLE;
							end else begin
								state_q <= ST_RDWAIT;
							end
						end
						default: begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_WALK: begin
					issue_s1 <= 1'b1;
					if (k_q == cmd_q.cycles) begin
						state_q <= ST_DRAIN;
					end else begin
						k_q    <= k_q + CYC_W'(1);
						addr_q <= addr_q + ADDR_W'(2);
					end
				end
				ST_DRAIN: begin
					result_q.wrapped <= wrap_q | cur_wrap;
					done_q           <= 1'b1;
					state_q          <= ST_IDLE;
				end
				ST_RDWAIT: begin
					result_q.coefficient <= $signed(store_rdata);
					done_q               <= 1'b1;
					state_q              <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

@@ sv/laurent_binomial_row_accumulator_top.sv @@
`timescale 1ns / 1ps
// Top level of the Laurent binomial row accumulator.
//
// Command channel: cmd is taken at a rising edge with start high and busy low.
// Result channel: one result word per command, on result for exactly one cycle
// while done is high; the receiver cannot stall it.
// Accumulate adds (or subtracts, odd weight) row c of Pascal's triangle into
// every second store entry from base = deg_offset - cycles + weight.
// Steps from accept to done, in order:
//   accumulate in range:      setup, a walk step per entry of row c, drain
//   read in range:            setup, store read
//   clear, no-op, rejected:   setup
// The walk is one read-modify-write of the store per cycle through a single
// adder, fed by the Pascal ROM; the store read port sets the step rate.
// A new command is taken in the cycle its predecessor's done is shown.
// Reset clears the store through per-entry valid bits at once; no sweep.
module laurent_binomial_row_accumulator_top (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  lbra_pkg::lbra_cmd_t    cmd,
	output logic                   busy,
	output logic                   done,
	output lbra_pkg::lbra_result_t result
);
	import lbra_pkg::*;

	lbra_store_req_t   store_req;
	logic [COEF_W-1:0] store_rdata;
	logic [ROM_AW-1:0] rom_addr;
	logic [COEF_W-1:0] rom_data;

	lbra_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.cmd         (cmd),
		.busy        (busy),
		.done        (done),
		.result      (result),
		.store_req   (store_req),
		.store_rdata (store_rdata),
		.rom_addr    (rom_addr),
		.rom_data    (rom_data)
	);

	lbra_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (store_req),
		.rdata  (store_rdata)
	);

	lbra_rom u_rom (
		.clk  (clk),
		.addr (rom_addr),
		.data (rom_data)
	);

endmodule

@@ sv/lbra_chk.sv @@
`timescale 1ns / 1ps
// Port-level checker for the row accumulator, bound to the top level.
module lbra_chk (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input lbra_pkg::lbra_cmd_t    cmd,
	input logic                   busy,
	input logic                   done,
	input lbra_pkg::lbra_result_t result
);
	import lbra_pkg::*;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result word shown while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accept");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.wrapped) |-> !result.out_of_range)
		else $error("wrap reported on rejected word");

	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.operation == OP_CLEAR) |=> ##1
		(done && result.coefficient == 0 && !result.wrapped && !result.out_of_range))
		else $error("clear result wrong or late");

	a_reject_cyc: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.operation == OP_ACCUMULATE
			&& cmd.cycles > CYC_W'(MAX_CYCLES)) |=> ##1
		(done && result.out_of_range))
		else $error("oversized accumulate not rejected");

endmodule

bind laurent_binomial_row_accumulator_top lbra_chk u_chk (.*);
